// ===== hw/rtl/lcfp_pkg.sv =====
// Package for the length/checksum frame parser.
// Holds register reset values, frame constants, status codes and the result word type.
// No dependencies.
`default_nettype none

package lcfp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 16;
    localparam int unsigned STAT_W = 2;

    // Register map of the configuration port
    localparam logic CFG_START_BYTE = 1'b0;
    localparam logic CFG_END_BYTE   = 1'b1;

    localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h5A;
    localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'h5B;

    localparam logic [LEN_W-1:0] MIN_FRAME_LEN = 16'd8;
    localparam logic [LEN_W-1:0] TRAILER_LEN   = 16'd2;

    localparam logic [STAT_W-1:0] ST_GOOD    = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_SUM = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_END = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  frame_length;
        logic [BYTE_W-1:0] seq_num;
        logic [BYTE_W-1:0] add_code;
        logic [BYTE_W-1:0] msg_code;
        logic [STAT_W-1:0] status;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/length_checksum_frame_parser.sv =====
// Length-prefixed frame parser with 8-bit additive checksum, top level.
// Depends on lcfp_pkg for constants, status codes and the result word type.
//
// Channel   Dir  Handshake                 Payload
// rx        in   i_rx_valid / o_rx_ready   i_rx_byte
// result    out  o_res_valid / i_res_ready o_data_byte .. o_last
// cfg       in   i_cfg_we (no wait)        i_cfg_idx, i_cfg_data
//
// One word per cycle while o_rx_ready is high: each byte is parsed in the cycle it is
// accepted; a result goes to the output register, or to the skid entry if it stays full.
// An output register plus one skid entry decouple the sides; o_rx_ready depends only
// on the skid entry, so input keeps flowing while one result waits.
// Synchronous active-low reset: parser hunts for the start byte, registers take
// their default values, no results pending.
`default_nettype none

module length_checksum_frame_parser
    import lcfp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [BYTE_W-1:0] i_cfg_data,
    // byte stream in
    input  wire logic              i_rx_valid,
    output logic                   o_rx_ready,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    // results out
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output logic [BYTE_W-1:0]      o_data_byte,
    output logic [LEN_W-1:0]       o_frame_length,
    output logic [BYTE_W-1:0]      o_seq_num,
    output logic [BYTE_W-1:0]      o_add_code,
    output logic [BYTE_W-1:0]      o_msg_code,
    output logic [STAT_W-1:0]      o_status,
    output logic                   o_last
);

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SEQ,
        PH_ADD,
        PH_MSG,
        PH_PAYLOAD,
        PH_CHK,
        PH_END
    } t_phase;

    logic [BYTE_W-1:0] r_start_byte;
    logic [BYTE_W-1:0] r_end_byte;

    t_phase            r_phase,       n_phase;
    logic [LEN_W-1:0]  r_length_seen, n_length_seen;
    logic [LEN_W-1:0]  r_bytes_taken, n_bytes_taken;
    logic [BYTE_W-1:0] r_running_sum, n_running_sum;
    logic [BYTE_W-1:0] r_seq_held,    n_seq_held;
    logic [BYTE_W-1:0] r_add_held,    n_add_held;
    logic [BYTE_W-1:0] r_msg_held,    n_msg_held;
    logic              r_sum_matched, n_sum_matched;

    t_result r_out, r_skid, n_res;
    logic    r_out_v, r_skid_v;

    logic             accept;
    logic             pop;
    logic             push;
    logic             has_res;
    logic [LEN_W-1:0] body_end;
    logic [LEN_W-1:0] bytes_inc;
    logic [BYTE_W-1:0] sum_add;

    assign accept    = i_rx_valid && o_rx_ready;
    assign pop       = r_out_v && i_res_ready;
    assign push      = accept && has_res;
    assign body_end  = r_length_seen - TRAILER_LEN;
    assign bytes_inc = r_bytes_taken + LEN_W'(1);
    assign sum_add   = r_running_sum + i_rx_byte;

    // ---------------- byte parser ----------------
    always_comb begin
        n_phase       = r_phase;
        n_length_seen = r_length_seen;
        n_bytes_taken = r_bytes_taken;
        n_running_sum = r_running_sum;
        n_seq_held    = r_seq_held;
        n_add_held    = r_add_held;
        n_msg_held    = r_msg_held;
        n_sum_matched = r_sum_matched;
        has_res       = 1'b0;
        n_res.data_byte    = '0;
        n_res.frame_length = r_length_seen;
        n_res.seq_num      = r_seq_held;
        n_res.add_code     = r_add_held;
        n_res.msg_code     = r_msg_held;
        n_res.status       = ST_GOOD;
        n_res.last         = 1'b0;

        case (r_phase)
            PH_HUNT: begin
                if (i_rx_byte == r_start_byte) begin
                    n_bytes_taken = LEN_W'(1);
                    n_running_sum = '0;
                    n_phase       = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                n_length_seen = {i_rx_byte, {BYTE_W{1'b0}}};
                n_running_sum = sum_add;
                n_bytes_taken = LEN_W'(2);
                n_phase       = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_length_seen = {r_length_seen[LEN_W-1:BYTE_W], i_rx_byte};
                n_running_sum = sum_add;
                n_bytes_taken = LEN_W'(3);
                // too short to hold header and trailer: drop it and hunt again
                n_phase = ({r_length_seen[LEN_W-1:BYTE_W], i_rx_byte} < MIN_FRAME_LEN)
                          ? PH_HUNT : PH_SEQ;
            end
            PH_SEQ: begin
                n_seq_held    = i_rx_byte;
                n_running_sum = sum_add;
                n_bytes_taken = LEN_W'(4);
                n_phase       = PH_ADD;
            end
            PH_ADD: begin
                n_add_held    = i_rx_byte;
                n_running_sum = sum_add;
                n_bytes_taken = LEN_W'(5);
                n_phase       = PH_MSG;
            end
            PH_MSG: begin
                n_msg_held    = i_rx_byte;
                n_running_sum = sum_add;
                n_bytes_taken = LEN_W'(6);
                n_phase       = (LEN_W'(6) < body_end) ? PH_PAYLOAD : PH_CHK;
            end
            PH_PAYLOAD: begin
                n_running_sum   = sum_add;
                n_bytes_taken   = bytes_inc;
                n_phase         = (bytes_inc < body_end) ? PH_PAYLOAD : PH_CHK;
                has_res         = 1'b1;
                n_res.data_byte = i_rx_byte;
            end
            PH_CHK: begin
                n_sum_matched = (i_rx_byte == r_running_sum);
                n_phase       = PH_END;
            end
            PH_END: begin
                // checksum failure wins over a bad end byte
                if (!r_sum_matched) begin
                    n_res.status = ST_BAD_SUM;
                end else if (i_rx_byte != r_end_byte) begin
                    n_res.status = ST_BAD_END;
                end
                n_res.last = 1'b1;
                has_res    = 1'b1;
                n_phase    = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte  <= START_BYTE_RST;
            r_end_byte    <= END_BYTE_RST;
            r_phase       <= PH_HUNT;
            r_length_seen <= '0;
            r_bytes_taken <= '0;
            r_running_sum <= '0;
            r_seq_held    <= '0;
            r_add_held    <= '0;
            r_msg_held    <= '0;
            r_sum_matched <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START_BYTE: r_start_byte <= i_cfg_data;
                    CFG_END_BYTE:   r_end_byte   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_phase       <= n_phase;
                r_length_seen <= n_length_seen;
                r_bytes_taken <= n_bytes_taken;
                r_running_sum <= n_running_sum;
                r_seq_held    <= n_seq_held;
                r_add_held    <= n_add_held;
                r_msg_held    <= n_msg_held;
                r_sum_matched <= n_sum_matched;
            end
        end
    end

    // ---------------- output register + skid entry ----------------
    assign o_rx_ready = !r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (pop) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_v || pop) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (pop) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (!r_out_v || pop) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign o_res_valid    = r_out_v;
    assign o_data_byte    = r_out.data_byte;
    assign o_frame_length = r_out.frame_length;
    assign o_seq_num      = r_out.seq_num;
    assign o_add_code     = r_out.add_code;
    assign o_msg_code     = r_out.msg_code;
    assign o_status       = r_out.status;
    assign o_last         = r_out.last;

    // ---------------- assertions ----------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry holds a word while the output register is empty");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == PH_END) |=> (r_out_v && (r_skid_v || r_out.last)))
        else $error("frame end byte did not produce a frame-end word");

    a_payload_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_bytes_taken >= LEN_W'(6)
                                     && r_bytes_taken < body_end))
        else $error("payload phase entered outside the frame body");

    a_payload_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out.last) |-> (r_out.status == ST_GOOD))
        else $error("payload word carries a nonzero status");

    a_end_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.last) |-> (r_out.data_byte == '0
                                     && r_out.frame_length >= MIN_FRAME_LEN))
        else $error("frame-end word has data or a short length");

endmodule

`default_nettype wire

// ===== tb/sv/length_checksum_frame_parser_test.sv =====
// Self-checking testbench for length_checksum_frame_parser: streams framed and noisy bytes,
// predicts payload words and frame-end words, and compares them field by field.
// Depends on lcfp_pkg and the length_checksum_frame_parser RTL.
`default_nettype none

module length_checksum_frame_parser_test;
    import lcfp_pkg::*;

    typedef enum logic [3:0] {
        HUNT_START, GET_LEN_HI, GET_LEN_LO, GET_SEQ, GET_ADD, GET_MSG,
        GET_PAYLOAD, GET_CHECK, GET_END
    } t_parse_state;

    typedef enum int {FRAME_OK, FRAME_BAD_SUM, FRAME_BAD_END, FRAME_BAD_BOTH} t_frame_fault;

    logic              i_clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic              cfg_idx = CFG_START_BYTE;
    logic [BYTE_W-1:0] cfg_data = '0;
    logic              rx_valid = 1'b0;
    logic [BYTE_W-1:0] rx_byte = '0;
    logic              res_ready = 1'b0;

    logic              o_rx_ready;
    logic              o_res_valid;
    logic [BYTE_W-1:0] o_data_byte;
    logic [LEN_W-1:0]  o_frame_length;
    logic [BYTE_W-1:0] o_seq_num;
    logic [BYTE_W-1:0] o_add_code;
    logic [BYTE_W-1:0] o_msg_code;
    logic [STAT_W-1:0] o_status;
    logic              o_last;

    length_checksum_frame_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_rx_valid     (rx_valid),
        .o_rx_ready     (o_rx_ready),
        .i_rx_byte      (rx_byte),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (res_ready),
        .o_data_byte    (o_data_byte),
        .o_frame_length (o_frame_length),
        .o_seq_num      (o_seq_num),
        .o_add_code     (o_add_code),
        .o_msg_code     (o_msg_code),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // register copies and parser state of the predictor
    logic [BYTE_W-1:0] start_sel = START_BYTE_RST;
    logic [BYTE_W-1:0] end_sel   = END_BYTE_RST;
    t_parse_state      parse_st  = HUNT_START;
    logic [LEN_W-1:0]  hdr_len   = '0;
    logic [LEN_W-1:0]  taken_cnt = '0;
    logic [BYTE_W-1:0] run_sum   = '0;
    logic [BYTE_W-1:0] seq_b     = '0;
    logic [BYTE_W-1:0] add_b     = '0;
    logic [BYTE_W-1:0] msg_b     = '0;
    logic              sum_ok    = 1'b0;

    // both lists only grow; a head index marks the next entry to consume
    logic [BYTE_W-1:0] rx_stream[$];
    int unsigned       rx_head  = 0;
    t_result           frame_results[$];
    int unsigned       res_head = 0;

    int unsigned fail_cnt  = 0;
    int unsigned rx_gap    = 0;
    int unsigned res_stall = 0;
    bit          rx_steady  = 1'b0;
    bit          res_steady = 1'b0;
    bit          hold_idle  = 1'b0;

    function automatic int unsigned idle_draw(bit steady);
        return (steady || hold_idle) ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic void stream_byte(logic [BYTE_W-1:0] b);
        rx_stream.insert(rx_stream.size(), b);
    endfunction

    function automatic void predict_word(t_result w);
        frame_results.insert(frame_results.size(), w);
    endfunction

    function automatic bit payload_pending();
        return 32'(taken_cnt) < 32'(hdr_len) - 32'(TRAILER_LEN);
    endfunction

    // advance the parser by one received byte, queue any word it yields
    function automatic void parse_byte(logic [BYTE_W-1:0] b);
        logic [STAT_W-1:0] st;
        case (parse_st)
            HUNT_START: begin
                if (b == start_sel) begin
                    taken_cnt = 16'd1;
                    run_sum   = '0;
                    parse_st  = GET_LEN_HI;
                end
            end
            GET_LEN_HI: begin
                hdr_len   = {b, 8'h00};
                run_sum   = run_sum + b;
                taken_cnt = 16'd2;
                parse_st  = GET_LEN_LO;
            end
            GET_LEN_LO: begin
                hdr_len[7:0] = b;
                run_sum      = run_sum + b;
                taken_cnt    = 16'd3;
                parse_st     = (hdr_len < MIN_FRAME_LEN) ? HUNT_START : GET_SEQ;
            end
            GET_SEQ: begin
                seq_b     = b;
                run_sum   = run_sum + b;
                taken_cnt = 16'd4;
                parse_st  = GET_ADD;
            end
            GET_ADD: begin
                add_b     = b;
                run_sum   = run_sum + b;
                taken_cnt = 16'd5;
                parse_st  = GET_MSG;
            end
            GET_MSG: begin
                msg_b     = b;
                run_sum   = run_sum + b;
                taken_cnt = 16'd6;
                parse_st  = payload_pending() ? GET_PAYLOAD : GET_CHECK;
            end
            GET_PAYLOAD: begin
                run_sum   = run_sum + b;
                taken_cnt = taken_cnt + 16'd1;
                parse_st  = payload_pending() ? GET_PAYLOAD : GET_CHECK;
                predict_word('{data_byte: b, frame_length: hdr_len, seq_num: seq_b,
                               add_code: add_b, msg_code: msg_b, status: ST_GOOD,
                               last: 1'b0});
            end
            GET_CHECK: begin
                sum_ok   = (b == run_sum);
                parse_st = GET_END;
            end
            GET_END: begin
                // checksum is judged before the end byte
                if (!sum_ok)
                    st = ST_BAD_SUM;
                else if (b != end_sel)
                    st = ST_BAD_END;
                else
                    st = ST_GOOD;
                parse_st = HUNT_START;
                predict_word('{data_byte: '0, frame_length: hdr_len, seq_num: seq_b,
                               add_code: add_b, msg_code: msg_b, status: st,
                               last: 1'b1});
            end
            default: parse_st = HUNT_START;
        endcase
    endfunction

    function automatic void note_fail(string msg);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("%0t: %s", $time, msg);
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
            note_fail($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
    endfunction

    // rx side: one byte per handshake, random gap before the next one unless steady or idle is held
    always @(posedge i_clk) begin
        if (!rst_n) begin
            rx_valid <= 1'b0;
            rx_gap = 0;
        end else begin
            if (rx_valid && o_rx_ready)
                parse_byte(rx_byte);
            if (!rx_valid || o_rx_ready) begin
                if (rx_gap > 0) begin
                    rx_gap--;
                    rx_valid <= 1'b0;
                end else if (rx_head < rx_stream.size()) begin
                    rx_byte  <= rx_stream[rx_head];
                    rx_valid <= 1'b1;
                    rx_head++;
                    rx_gap = idle_draw(rx_steady);
                    if ($urandom_range(0, 63) == 0)
                        rx_steady = !rx_steady;
                end else begin
                    rx_valid <= 1'b0;
                end
            end
        end
    end

    // result side: compare each accepted word with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (!rst_n) begin
            res_ready <= 1'b0;
            res_stall = 0;
        end else begin
            if (o_res_valid && res_ready) begin
                if (res_head >= frame_results.size()) begin
                    note_fail($sformatf("unexpected word: data %0h len %0h last %0b status %0d",
                                        o_data_byte, o_frame_length, o_last, o_status));
                end else begin
                    want = frame_results[res_head];
                    res_head++;
                    check_field("data_byte", 16'(want.data_byte), 16'(o_data_byte));
                    check_field("frame_length", want.frame_length, o_frame_length);
                    check_field("seq_num", 16'(want.seq_num), 16'(o_seq_num));
                    check_field("add_code", 16'(want.add_code), 16'(o_add_code));
                    check_field("msg_code", 16'(want.msg_code), 16'(o_msg_code));
                    check_field("status", 16'(want.status), 16'(o_status));
                    check_field("last", 16'(want.last), 16'(o_last));
                end
                res_stall = idle_draw(res_steady);
                if ($urandom_range(0, 63) == 0)
                    res_steady = !res_steady;
                res_ready <= (res_stall == 0);
            end else if (res_stall > 0) begin
                res_stall--;
                res_ready <= (res_stall == 0);
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic idx, logic [BYTE_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_START_BYTE)
            start_sel = val;
        else
            end_sel = val;
    endtask

    // wait until every word is in and checked, then let the pipeline settle
    task automatic drain();
        while (rx_head < rx_stream.size() || rx_valid || res_head < frame_results.size())
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_frame(logic [LEN_W-1:0] len, logic [BYTE_W-1:0] seq,
                               logic [BYTE_W-1:0] add, logic [BYTE_W-1:0] msg,
                               logic [BYTE_W-1:0] first_pl, t_frame_fault fault);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        int unsigned       i;
        stream_byte(start_sel);
        stream_byte(len[15:8]);
        stream_byte(len[7:0]);
        stream_byte(seq);
        stream_byte(add);
        stream_byte(msg);
        sum = len[15:8] + len[7:0] + seq + add + msg;
        for (i = 0; i < 32'(len) - 8; i++) begin
            if (i == 0)
                b = first_pl;
            else if ($urandom_range(0, 7) == 0)
                b = start_sel;
            else
                b = 8'($urandom);
            stream_byte(b);
            sum = sum + b;
        end
        if (fault == FRAME_BAD_SUM || fault == FRAME_BAD_BOTH)
            sum = sum ^ 8'($urandom_range(1, 255));
        stream_byte(sum);
        if (fault == FRAME_BAD_END || fault == FRAME_BAD_BOTH)
            stream_byte(end_sel ^ 8'($urandom_range(1, 255)));
        else
            stream_byte(end_sel);
    endtask

    // mostly well-formed frames, plus short lengths, faults and line noise
    task automatic queue_random(int unsigned budget);
        int unsigned       made;
        int unsigned       pick;
        int unsigned       n;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] b;
        t_frame_fault      fault;
        made = 0;
        while (made < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    do b = 8'($urandom); while (b == start_sel);
                    stream_byte(b);
                end
            end else if (pick < 12) begin
                stream_byte(start_sel);
                stream_byte(8'h00);
                stream_byte(8'($urandom_range(0, 7)));
                made += 3;
            end else begin
                if ($urandom_range(0, 15) == 0)
                    len = 16'(8 + $urandom_range(0, 250));
                else
                    len = 16'(8 + $urandom_range(0, 16));
                if (pick < 78)
                    fault = FRAME_OK;
                else if (pick < 86)
                    fault = FRAME_BAD_SUM;
                else if (pick < 94)
                    fault = FRAME_BAD_END;
                else
                    fault = FRAME_BAD_BOTH;
                b = ($urandom_range(0, 3) == 0) ? start_sel : 8'($urandom);
                queue_frame(len, 8'($urandom), 8'($urandom), 8'($urandom), b, fault);
                made += 32'(len);
            end
        end
    endtask

    initial begin
        logic [BYTE_W-1:0] shared;
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // register reset values; short length, start byte in payload, both faults, bad end
        stream_byte(start_sel);
        stream_byte(8'h00);
        stream_byte(8'h07);
        queue_frame(16'd9, 8'hFF, 8'h00, 8'h80, start_sel, FRAME_OK);
        queue_frame(16'd8, 8'h01, 8'hFE, 8'h7F, 8'h00, FRAME_BAD_BOTH);
        queue_frame(16'd9, 8'h00, 8'hFF, 8'hFF, 8'hFF, FRAME_BAD_END);
        queue_random(120);
        drain();

        write_reg(CFG_START_BYTE, 8'h00);
        write_reg(CFG_END_BYTE, 8'hFF);
        queue_random(120);
        drain();

        write_reg(CFG_START_BYTE, 8'hFF);
        write_reg(CFG_END_BYTE, 8'h00);
        queue_random(120);
        drain();

        shared = 8'($urandom);
        write_reg(CFG_START_BYTE, shared);
        write_reg(CFG_END_BYTE, shared);
        queue_random(120);
        drain();

        // a frame whose length needs the high byte, streamed without idling
        write_reg(CFG_START_BYTE, 8'($urandom));
        write_reg(CFG_END_BYTE, 8'($urandom));
        hold_idle = 1'b1;
        queue_frame(16'd300, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), FRAME_OK);
        drain();
        hold_idle = 1'b0;
        queue_random(120);
        drain();

        repeat (16) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #6_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/lcfp_pkg.sv
hw/rtl/length_checksum_frame_parser.sv
tb/sv/length_checksum_frame_parser_test.sv
